/* hdl/rgc_pkg.sv */
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared types, constants and the trig table for the grid ray caster.
// ----------------------------------------------------------------------------
package rgc_pkg;

    localparam int NUM_RAYS      = 60;
    localparam int MAX_STEPS     = 8;
    localparam int CELL_SHIFT    = 6;
    localparam int FRAC_BITS     = 6;
    localparam int GRID_SHIFT    = CELL_SHIFT + FRAC_BITS;
    localparam int MAP_CELLS     = 64;
    localparam int SCREEN_HEIGHT = 320;
    localparam int HALF_FOV      = NUM_RAYS / 2;

    localparam int COORD_W = 24;   // signed q.6 coordinates and distances
    localparam int PROD_W  = 41;   // 24 x 17 signed product
    localparam int DIV_NW  = 27;   // divider dividend / quotient
    localparam int DIV_DW  = 24;   // divider divisor

    localparam int RAY_DEPTH = 4;
    localparam int RES_DEPTH = 2;

    localparam logic signed [COORD_W-1:0] CELL_Q6   = COORD_W'(1 << GRID_SHIFT);
    localparam logic signed [COORD_W-1:0] MISS_DIST = COORD_W'(100000 * 64);

    // configuration register indexes
    localparam logic [1:0] CFG_CELLS  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_SCALE  = 2'd3;

    localparam logic [14:0] QSINE [0:90] = '{
        15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
        15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
        15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5871,
        15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
        15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
        15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
        15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085,
        15'd13255, 15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849,
        15'd14968, 15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491,
        15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964,
        15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    typedef struct packed {
        logic [14:0]        px;
        logic [14:0]        py;
        logic [5:0]         col;
        logic signed [15:0] s;
        logic signed [15:0] c;
        logic [14:0]        fc;
        logic               last;
    } ray_t;

    typedef struct packed {
        logic [5:0]         column;
        logic [7:0]         wall_top;
        logic [8:0]         wall_height;
        logic               vertical_hit;
        logic signed [17:0] hit_x;
        logic signed [17:0] hit_y;
        logic               last_column;
    } res_t;

    typedef struct packed {
        logic [63:0] cells;
        logic [3:0]  width;
        logic [3:0]  height;
        logic [7:0]  scale;
    } map_cfg_t;

    function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
        logic [8:0]  i;
        logic [14:0] v;
        if (a <= 9'd90)
            i = a;
        else if (a <= 9'd180)
            i = 9'd180 - a;
        else if (a <= 9'd270)
            i = a - 9'd180;
        else
            i = 9'd360 - a;
        v = QSINE[i[6:0]];
        return (a > 9'd180) ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    function automatic logic signed [15:0] cos_deg(input logic [8:0] a);
        logic [8:0] b;
        b = a + 9'd90;
        if (b >= 9'd360)
            b = b - 9'd360;
        return sin_deg(b);
    endfunction

    // divide by 2^14, rounding half away from zero
    function automatic logic signed [COORD_W-1:0] round_q14(input logic signed [41:0] v);
        logic [41:0] mag;
        logic [41:0] q;
        mag = v[41] ? 42'(-v) : 42'(v);
        q   = (mag + 42'd8192) >> 14;
        return v[41] ? -$signed(q[COORD_W-1:0]) : $signed(q[COORD_W-1:0]);
    endfunction

endpackage

/* hdl/rgc_fifo.sv */
// ----------------------------------------------------------------------------
// rgc_fifo
// Small register queue, power-of-two depth.
// ----------------------------------------------------------------------------
module rgc_fifo
    import rgc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = RES_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rp_reg;
    logic [AW:0]      cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hdl/rgc_front.sv */
// ----------------------------------------------------------------------------
// rgc_front
// Takes a pose and issues one ray descriptor per column: position, sine,
// cosine and fisheye factor.
// ----------------------------------------------------------------------------
module rgc_front
    import rgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_push,
    output logic        in_full,
    input  logic [14:0] pos_x,
    input  logic [14:0] pos_y,
    input  logic [8:0]  view_deg,
    output logic        ray_wr,
    output ray_t        ray_data,
    input  logic        ray_full
);

    logic        busy_reg;
    logic [5:0]  col_reg;
    logic [8:0]  ang_reg;
    logic [14:0] px_reg;
    logic [14:0] py_reg;
    logic [8:0]  view_mod;
    logic [9:0]  a0_wide;
    logic [8:0]  a0;
    logic [5:0]  off;
    logic        accept;

    assign in_full  = busy_reg;
    assign accept   = in_push && !busy_reg;
    assign ray_wr   = busy_reg && !ray_full;

    assign view_mod = (view_deg >= 9'd360) ? view_deg - 9'd360 : view_deg;
    assign a0_wide  = 10'(view_mod) + 10'(180 + HALF_FOV);
    assign a0       = (a0_wide >= 10'd360) ? 9'(a0_wide - 10'd360) : 9'(a0_wide);
    assign off      = (col_reg < 6'(HALF_FOV)) ? 6'(HALF_FOV) - col_reg
                                               : col_reg - 6'(HALF_FOV);

    always_comb
    begin
        ray_data.px   = px_reg;
        ray_data.py   = py_reg;
        ray_data.col  = col_reg;
        ray_data.s    = sin_deg(ang_reg);
        ray_data.c    = cos_deg(ang_reg);
        ray_data.fc   = QSINE[7'(7'd90 - 7'(off))];
        ray_data.last = (col_reg == 6'(NUM_RAYS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            ang_reg  <= '0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
            col_reg  <= '0;
            ang_reg  <= a0;
        end
        else if (ray_wr)
        begin
            // rays sweep clockwise, one degree per column
            ang_reg <= (ang_reg == 9'd0) ? 9'd359 : ang_reg - 9'd1;
            col_reg <= col_reg + 6'd1;
            if (col_reg == 6'(NUM_RAYS - 1))
                busy_reg <= 1'b0;
        end
    end

endmodule

/* hdl/rgc_div.sv */
// ----------------------------------------------------------------------------
// rgc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rgc_div
    import rgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quo
);

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_DW:0]   rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW+1:0] trial;

    assign done   = done_reg;
    assign quo    = quo_reg;
    assign rem_sh = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
    assign trial  = {1'b0, rem_sh} - {2'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_DW+1])
            begin
                rem_reg <= trial[DIV_DW:0];
                quo_reg <= {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_NW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* hdl/rgc_back.sv */
// ----------------------------------------------------------------------------
// rgc_back
// Casts one ray: vertical and horizontal grid walks, nearest hit,
// fisheye correction and projected height.
// ----------------------------------------------------------------------------
module rgc_back
    import rgc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  map_cfg_t cfg,
    input  ray_t     ray_data,
    input  logic     ray_empty,
    output logic     ray_rd,
    output logic     res_wr,
    output res_t     res_data,
    input  logic     res_full
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_DIV1W = 4'd3;
    localparam logic [3:0] S_DIV2W = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_DIST1 = 4'd6;
    localparam logic [3:0] S_DIST2 = 4'd7;
    localparam logic [3:0] S_PHASE = 4'd8;
    localparam logic [3:0] S_PICK  = 4'd9;
    localparam logic [3:0] S_CORR  = 4'd10;
    localparam logic [3:0] S_HDIV  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam int SW = $clog2(MAX_STEPS);
    localparam int MW = COORD_W - GRID_SHIFT;

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    ray_t                      ray_reg;
    logic                      phase_reg;
    logic signed [COORD_W-1:0] m_reg;
    logic signed [COORD_W-1:0] o_reg;
    logic signed [COORD_W-1:0] sm_reg;
    logic                      neg_reg;
    logic signed [COORD_W-1:0] rx_reg;
    logic signed [COORD_W-1:0] ry_reg;
    logic signed [COORD_W-1:0] sx_reg;
    logic signed [COORD_W-1:0] sy_reg;
    logic [SW-1:0]             cnt_reg;
    logic signed [COORD_W-1:0] dist_reg;
    logic signed [COORD_W-1:0] dv_reg;
    logic signed [COORD_W-1:0] vx_reg;
    logic signed [COORD_W-1:0] vy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  mul_reg;
    logic                      vert_reg;
    logic [8:0]                height_reg;

    logic signed [15:0]        d_sel;
    logic signed [15:0]        f_sel;
    logic signed [COORD_W-1:0] px_c;
    logic signed [COORD_W-1:0] py_c;
    logic signed [COORD_W-1:0] pm_c;
    logic signed [COORD_W-1:0] po_c;
    logic [14:0]               pm;
    logic                      dir_pos;
    logic signed [COORD_W-1:0] base_c;
    logic signed [COORD_W-1:0] m0;
    logic signed [COORD_W-1:0] sm0;
    logic signed [COORD_W-1:0] mul_a;
    logic signed [16:0]        mul_b;
    logic                      mul_neg;
    logic [PROD_W-1:0]         mul_mag;
    logic [15:0]               dmag;
    logic [DIV_NW-1:0]         round_num;
    logic                      div_start;
    logic [DIV_NW-1:0]         div_num;
    logic [DIV_DW-1:0]         div_den;
    logic                      div_done;
    logic [DIV_NW-1:0]         div_quo;
    logic signed [COORD_W-1:0] q_s;
    logic signed [MW-1:0]      mx;
    logic signed [MW-1:0]      my;
    logic signed [17:0]        idx;
    logic [7:0]                limit;
    logic                      cell_hit;
    logic                      vert_now;
    logic signed [COORD_W-1:0] dist_sel;
    logic signed [41:0]        dist_diff;
    logic signed [COORD_W-1:0] corr;

    function automatic logic signed [17:0] sat18(input logic signed [COORD_W-1:0] v);
        if (v > COORD_W'(131071))
            return 18'sd131071;
        else if (v < -COORD_W'(131072))
            return -18'sd131072;
        else
            return v[17:0];
    endfunction

    assign px_c    = COORD_W'(ray_reg.px);
    assign py_c    = COORD_W'(ray_reg.py);
    // phase 0 walks vertical grid lines, phase 1 horizontal ones
    assign d_sel   = phase_reg ? ray_reg.s : ray_reg.c;
    assign f_sel   = phase_reg ? ray_reg.c : ray_reg.s;
    assign pm      = phase_reg ? ray_reg.py : ray_reg.px;
    assign pm_c    = phase_reg ? py_c : px_c;
    assign po_c    = phase_reg ? px_c : py_c;
    assign dir_pos = phase_reg ? ray_reg.s[15] : (ray_reg.c > 16'sd0);
    assign base_c  = COORD_W'({pm[14:GRID_SHIFT], GRID_SHIFT'(0)});
    assign m0      = dir_pos ? base_c + CELL_Q6 : base_c - COORD_W'(1);
    assign sm0     = dir_pos ? CELL_Q6 : -CELL_Q6;

    assign vert_now = dv_reg < dist_reg;
    assign dist_sel = vert_now ? dv_reg : dist_reg;

    // shared multiplier, operands picked by state
    always_comb
    begin
        case (state_reg)
            S_SETUP:
            begin
                mul_a = pm_c - m0;
                mul_b = 17'(f_sel);
            end
            S_DIV1, S_DIV1W:
            begin
                mul_a = -sm_reg;
                mul_b = 17'(f_sel);
            end
            S_DIST1:
            begin
                mul_a = ry_reg - py_c;
                mul_b = 17'(ray_reg.s);
            end
            S_PICK:
            begin
                mul_a = dist_sel;
                mul_b = $signed({2'b0, ray_reg.fc});
            end
            default:
            begin
                mul_a = rx_reg - px_c;
                mul_b = 17'(ray_reg.c);
            end
        endcase
    end

    assign mul_neg   = mul_reg[PROD_W-1];
    assign mul_mag   = mul_neg ? PROD_W'(-mul_reg) : PROD_W'(mul_reg);
    assign dmag      = d_sel[15] ? 16'(-d_sel) : 16'(d_sel);
    assign round_num = mul_mag[DIV_NW-1:0] + DIV_NW'(dmag >> 1);
    assign q_s       = neg_reg ? -$signed(div_quo[COORD_W-1:0])
                               : $signed(div_quo[COORD_W-1:0]);

    assign dist_diff = prod_reg - mul_reg;
    assign corr      = round_q14(42'(mul_reg));

    // cell lookup
    assign mx       = rx_reg[COORD_W-1:GRID_SHIFT];
    assign my       = ry_reg[COORD_W-1:GRID_SHIFT];
    assign idx      = 18'(my * $signed({1'b0, cfg.width})) + 18'(mx);
    assign limit    = 8'(cfg.width) * 8'(cfg.height);
    assign cell_hit = (idx > 18'sd0) && (idx < $signed({10'b0, limit}))
                   && (idx < 18'(MAP_CELLS)) && cfg.cells[idx[5:0]];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = round_num;
        div_den   = DIV_DW'(dmag);
        case (state_reg)
            S_DIV1:
                div_start = 1'b1;
            S_DIV1W:
                div_start = div_done;
            S_CORR:
            begin
                div_start = (corr > COORD_W'(0));
                div_num   = DIV_NW'(cfg.scale) * DIV_NW'(SCREEN_HEIGHT << FRAC_BITS);
                div_den   = DIV_DW'(corr);
            end
            default:
                div_start = 1'b0;
        endcase
    end

    rgc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign ray_rd = (state_reg == S_IDLE) && !ray_empty;
    assign res_wr = (state_reg == S_OUT) && !res_full;

    always_comb
    begin
        res_data.column       = ray_reg.col;
        res_data.wall_top     = 8'(9'(SCREEN_HEIGHT / 2) - (height_reg >> 1));
        res_data.wall_height  = height_reg;
        res_data.vertical_hit = vert_reg;
        res_data.hit_x        = sat18(rx_reg);
        res_data.hit_y        = sat18(ry_reg);
        res_data.last_column  = ray_reg.last;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (!ray_empty)
                    state_next = S_SETUP;
            S_SETUP:
                state_next = (d_sel == 16'sd0) ? S_PHASE : S_DIV1;
            S_DIV1:
                state_next = S_DIV1W;
            S_DIV1W:
                if (div_done)
                    state_next = S_DIV2W;
            S_DIV2W:
                if (div_done)
                    state_next = S_WALK;
            S_WALK:
                if (cell_hit)
                    state_next = S_DIST1;
                else if (cnt_reg == SW'(MAX_STEPS - 1))
                    state_next = S_PHASE;
            S_DIST1:
                state_next = S_DIST2;
            S_DIST2:
                state_next = S_PHASE;
            S_PHASE:
                state_next = phase_reg ? S_PICK : S_SETUP;
            S_PICK:
                state_next = S_CORR;
            S_CORR:
                state_next = (corr > COORD_W'(0)) ? S_HDIV : S_OUT;
            S_HDIV:
                if (div_done)
                    state_next = S_OUT;
            S_OUT:
                if (!res_full)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                ray_reg   <= ray_data;
                phase_reg <= 1'b0;
            end
            S_SETUP:
            begin
                m_reg  <= m0;
                sm_reg <= sm0;
                // axis-parallel ray: no walk on this axis
                rx_reg   <= px_c;
                ry_reg   <= py_c;
                dist_reg <= MISS_DIST;
            end
            S_DIV1:
                neg_reg <= mul_neg ^ d_sel[15];
            S_DIV1W:
                if (div_done)
                begin
                    o_reg   <= po_c + q_s;
                    neg_reg <= mul_neg ^ d_sel[15];
                end
            S_DIV2W:
                if (div_done)
                begin
                    cnt_reg <= '0;
                    if (!phase_reg)
                    begin
                        rx_reg <= m_reg;
                        ry_reg <= o_reg;
                        sx_reg <= sm_reg;
                        sy_reg <= q_s;
                    end
                    else
                    begin
                        rx_reg <= o_reg;
                        ry_reg <= m_reg;
                        sx_reg <= q_s;
                        sy_reg <= sm_reg;
                    end
                end
            S_WALK:
                if (!cell_hit)
                begin
                    rx_reg   <= rx_reg + sx_reg;
                    ry_reg   <= ry_reg + sy_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                    dist_reg <= MISS_DIST;
                end
            S_DIST1:
                prod_reg <= mul_reg;
            S_DIST2:
                dist_reg <= round_q14(dist_diff);
            S_PHASE:
                if (!phase_reg)
                begin
                    dv_reg    <= dist_reg;
                    vx_reg    <= rx_reg;
                    vy_reg    <= ry_reg;
                    phase_reg <= 1'b1;
                end
            S_PICK:
            begin
                vert_reg <= vert_now;
                dist_reg <= dist_sel;
                if (vert_now)
                begin
                    rx_reg <= vx_reg;
                    ry_reg <= vy_reg;
                end
            end
            S_CORR:
                height_reg <= 9'(SCREEN_HEIGHT);
            S_HDIV:
                if (div_done)
                    height_reg <= (div_quo > DIV_NW'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT)
                                                                     : div_quo[8:0];
            default:
                phase_reg <= phase_reg;
        endcase
    end

endmodule

/* hdl/grid_raycaster_columns.sv */
// ----------------------------------------------------------------------------
// grid_raycaster_columns
// Grid ray caster: one pose in, one wall column out per ray.
// ----------------------------------------------------------------------------
// Input channel: a pose beat (pos_x, pos_y, view_deg) is taken when push is
// high and full is low. full stays high while the front end issues the 60
// ray descriptors of a pose into a four-entry ray queue.
// Output channel: a queue face; while empty is low the oldest column is on
// the result ports and pop takes it. 60 columns per pose, last_column marks
// the final one.
// Each column is worked by one sequencer around a shared 24x17 multiplier
// and a 27-bit restoring divider. A column costs two setup divisions per
// walk axis, up to 8 walk steps per axis, and at most one height division;
// it costs less when a walk hits early or the ray runs along an axis. The
// divider sets most of that cost.
// Map registers are written through cfg_wr / cfg_index / cfg_data with no
// wait state. Reset empties both queues and loads an empty 8x8 map with
// scale 64. When pop is held low the back end stops once the two-entry
// result queue fills, and the front end stops once the ray queue fills.
// ----------------------------------------------------------------------------
module grid_raycaster_columns
    import rgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [14:0]        pos_x,
    input  logic [14:0]        pos_y,
    input  logic [8:0]         view_deg,
    output logic               empty,
    input  logic               pop,
    output logic [5:0]         column,
    output logic [7:0]         wall_top,
    output logic [8:0]         wall_height,
    output logic               vertical_hit,
    output logic signed [17:0] hit_x,
    output logic signed [17:0] hit_y,
    output logic               last_column,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    map_cfg_t cfg_reg;
    logic     ray_wr;
    ray_t     ray_in;
    logic     ray_full;
    logic     ray_rd;
    ray_t     ray_out;
    logic     ray_empty;
    logic     res_wr;
    res_t     res_in;
    logic     res_full;
    res_t     res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cells  <= '0;
            cfg_reg.width  <= 4'd8;
            cfg_reg.height <= 4'd8;
            cfg_reg.scale  <= 8'd64;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_CELLS:  cfg_reg.cells  <= cfg_data;
                CFG_WIDTH:  cfg_reg.width  <= cfg_data[3:0];
                CFG_HEIGHT: cfg_reg.height <= cfg_data[3:0];
                CFG_SCALE:  cfg_reg.scale  <= cfg_data[7:0];
                default:    cfg_reg.scale  <= cfg_reg.scale;
            endcase
        end
    end

    rgc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_push  (push),
        .in_full  (full),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .view_deg (view_deg),
        .ray_wr   (ray_wr),
        .ray_data (ray_in),
        .ray_full (ray_full)
    );

    rgc_fifo #(
        .WIDTH ($bits(ray_t)),
        .DEPTH (RAY_DEPTH)
    ) u_ray_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ray_wr),
        .wr_data (ray_in),
        .full    (ray_full),
        .rd      (ray_rd),
        .rd_data (ray_out),
        .empty   (ray_empty)
    );

    rgc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ray_data  (ray_out),
        .ray_empty (ray_empty),
        .ray_rd    (ray_rd),
        .res_wr    (res_wr),
        .res_data  (res_in),
        .res_full  (res_full)
    );

    rgc_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd      (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign column       = res_out.column;
    assign wall_top     = res_out.wall_top;
    assign wall_height  = res_out.wall_height;
    assign vertical_hit = res_out.vertical_hit;
    assign hit_x        = res_out.hit_x;
    assign hit_y        = res_out.hit_y;
    assign last_column  = res_out.last_column;

endmodule

/* sim/rgc_column_checker.sv */
// ----------------------------------------------------------------------------
// rgc_column_checker
// Watches the pose, column and map write channels of the grid ray caster,
// predicts the 60 wall columns of every accepted pose and compares each
// popped column with the oldest prediction.
// ----------------------------------------------------------------------------
module rgc_column_checker
    import rgc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [14:0]        pos_x,
    input  logic [14:0]        pos_y,
    input  logic [8:0]         view_deg,
    input  logic               empty,
    input  logic               pop,
    input  logic [5:0]         column,
    input  logic [7:0]         wall_top,
    input  logic [8:0]         wall_height,
    input  logic               vertical_hit,
    input  logic signed [17:0] hit_x,
    input  logic signed [17:0] hit_y,
    input  logic               last_column,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output int                 mismatches,
    output int                 columns_pending
);

    localparam longint GRID_Q6   = 64'd4096;
    localparam longint FAR_DIST  = 64'd6400000;
    localparam longint TRIG_UNIT = 64'd16384;

    res_t        column_queue[$];
    logic [63:0] wall_bits;
    logic [3:0]  grid_w;
    logic [3:0]  grid_h;
    logic [7:0]  wall_scale;

    function automatic longint sine_of(int d);
        d = d % 360;
        if (d <= 90)
            return longint'(QSINE[d]);
        else if (d <= 180)
            return longint'(QSINE[180 - d]);
        else if (d <= 270)
            return -longint'(QSINE[d - 180]);
        return -longint'(QSINE[360 - d]);
    endfunction

    // half away from zero
    function automatic longint div_nearest(longint n, longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint march_ray(inout longint rx, inout longint ry,
                                         input longint sx, input longint sy,
                                         input longint px, input longint py,
                                         input longint s, input longint c);
        longint area;
        longint idx;
        area = longint'(grid_w) * longint'(grid_h);
        for (int n = 0; n < MAX_STEPS; n++)
        begin
            idx = (ry >>> GRID_SHIFT) * longint'(grid_w) + (rx >>> GRID_SHIFT);
            if (idx > 0 && idx < area && idx < MAP_CELLS && wall_bits[idx])
                return div_nearest(c * (rx - px) - s * (ry - py), TRIG_UNIT);
            rx += sx;
            ry += sy;
        end
        return FAR_DIST;
    endfunction

    function automatic logic signed [17:0] clamp_q6(longint v);
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[17:0];
    endfunction

    task automatic predict_columns(input logic [14:0] x, input logic [14:0] y,
                                   input logic [8:0] heading);
        longint px, py, s, c, vx, vy, hx, hy, dv, dh, ray_dist, corr, base, stx, sty;
        longint tall;
        int     a, off;
        bit     vert;
        res_t   r;
        px = longint'(x);
        py = longint'(y);
        for (int k = 0; k < NUM_RAYS; k++)
        begin
            a  = (int'(heading) % 360 + 180 + HALF_FOV + 360 - k) % 360;
            s  = sine_of(a);
            c  = sine_of(a + 90);
            vx = px; vy = py; hx = px; hy = py;
            dv = FAR_DIST;
            dh = FAR_DIST;
            if (c != 0)
            begin
                base = (px >>> GRID_SHIFT) << GRID_SHIFT;
                if (c > 0)
                begin
                    vx = base + GRID_Q6; stx = GRID_Q6;
                end
                else
                begin
                    vx = base - 1; stx = -GRID_Q6;
                end
                vy  = py + div_nearest((px - vx) * s, c);
                sty = div_nearest(-stx * s, c);
                dv  = march_ray(vx, vy, stx, sty, px, py, s, c);
            end
            if (s != 0)
            begin
                base = (py >>> GRID_SHIFT) << GRID_SHIFT;
                if (s > 0)
                begin
                    hy = base - 1; sty = -GRID_Q6;
                end
                else
                begin
                    hy = base + GRID_Q6; sty = GRID_Q6;
                end
                hx  = px + div_nearest((py - hy) * c, s);
                stx = div_nearest(-sty * c, s);
                dh  = march_ray(hx, hy, stx, sty, px, py, s, c);
            end
            vert     = dv < dh;
            ray_dist = vert ? dv : dh;
            off      = (k < HALF_FOV) ? HALF_FOV - k : k - HALF_FOV;
            corr     = div_nearest(ray_dist * sine_of(off + 90), TRIG_UNIT);
            if (corr <= 0)
                tall = SCREEN_HEIGHT;
            else
            begin
                tall = (longint'(wall_scale) * SCREEN_HEIGHT * 64) / corr;
                if (tall > SCREEN_HEIGHT)
                    tall = SCREEN_HEIGHT;
            end
            r.column       = 6'(k);
            r.wall_height  = 9'(tall);
            r.wall_top     = 8'(SCREEN_HEIGHT / 2 - (tall >> 1));
            r.vertical_hit = vert;
            r.hit_x        = clamp_q6(vert ? vx : hx);
            r.hit_y        = clamp_q6(vert ? vy : hy);
            r.last_column  = (k == NUM_RAYS - 1);
            column_queue.push_back(r);
        end
    endtask

    task automatic report(input string what, input longint exp_v, input longint act_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            column_queue.delete();
            mismatches = 0;
            wall_bits  = '0;
            grid_w     = 4'd8;
            grid_h     = 4'd8;
            wall_scale = 8'd64;
            columns_pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (column_queue.size() == 0)
                begin
                    $display("%0t: column beat with nothing expected, got column %0d",
                             $time, column);
                    mismatches++;
                end
                else
                begin
                    e = column_queue.pop_front();
                    if (column != e.column)
                        report("column", e.column, column);
                    if (wall_top != e.wall_top)
                        report("wall_top", e.wall_top, wall_top);
                    if (wall_height != e.wall_height)
                        report("wall_height", e.wall_height, wall_height);
                    if (vertical_hit != e.vertical_hit)
                        report("vertical_hit", e.vertical_hit, vertical_hit);
                    if (hit_x != e.hit_x)
                        report("hit_x", e.hit_x, hit_x);
                    if (hit_y != e.hit_y)
                        report("hit_y", e.hit_y, hit_y);
                    if (last_column != e.last_column)
                        report("last_column", e.last_column, last_column);
                end
            end
            if (push && !full)
                predict_columns(pos_x, pos_y, view_deg);
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_CELLS:  wall_bits  = cfg_data;
                    CFG_WIDTH:  grid_w     = cfg_data[3:0];
                    CFG_HEIGHT: grid_h     = cfg_data[3:0];
                    CFG_SCALE:  wall_scale = cfg_data[7:0];
                    default: ;
                endcase
            end
            columns_pending = column_queue.size();
        end
    end

endmodule

/* sim/tb_grid_raycaster_columns.sv */
// ----------------------------------------------------------------------------
// tb_grid_raycaster_columns
// Drives poses and map settings into the grid ray caster with random gaps and
// pop stalls, including a long pop hold-off that backs the block up; the
// column checker predicts and compares every column.
// ----------------------------------------------------------------------------
module tb_grid_raycaster_columns;
    import rgc_pkg::*;

    localparam longint CYCLE_LIMIT = 40000000;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [14:0]        pos_x;
    logic [14:0]        pos_y;
    logic [8:0]         view_deg;
    logic               empty;
    logic               pop;
    logic [5:0]         column;
    logic [7:0]         wall_top;
    logic [8:0]         wall_height;
    logic               vertical_hit;
    logic signed [17:0] hit_x;
    logic signed [17:0] hit_y;
    logic               last_column;
    logic               cfg_wr;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    int     mismatches;
    int     columns_pending;
    int     send_idle_pct;
    int     pop_idle_pct;
    int     hold_cycles;
    longint cycle_count;

    grid_raycaster_columns dut (.*);

    rgc_column_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pos_x     = '0;
        pos_y     = '0;
        view_deg  = '0;
        pop       = 1'b0;
        cfg_wr    = 1'b0;
        cfg_index = CFG_CELLS;
        cfg_data  = '0;
        send_idle_pct = 0;
        pop_idle_pct  = 0;
        hold_cycles   = 0;
        cycle_count   = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // pop side: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            pop <= ($urandom_range(99) >= pop_idle_pct);
    end

    task automatic send_pose(input logic [14:0] x, input logic [14:0] y,
                             input logic [8:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        push     <= 1'b1;
        pos_x    <= x;
        pos_y    <= y;
        view_deg <= v;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain_and_write(input logic [63:0] cells, input logic [3:0] w,
                                   input logic [3:0] h, input logic [7:0] sc);
        push <= 1'b0;
        @(posedge clk);
        while (columns_pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        cfg_wr <= 1'b1; cfg_index <= CFG_CELLS;  cfg_data <= cells;
        @(posedge clk);
        cfg_index <= CFG_WIDTH;  cfg_data <= 64'(w);
        @(posedge clk);
        cfg_index <= CFG_HEIGHT; cfg_data <= 64'(h);
        @(posedge clk);
        cfg_index <= CFG_SCALE;  cfg_data <= 64'(sc);
        @(posedge clk);
        cfg_wr <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] cells;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty map after reset: every ray misses
        send_pose(15'd0, 15'd0, 9'd0);
        send_pose(15'h7fff, 15'h7fff, 9'd359);
        send_pose(15'd16384, 15'd16384, 9'd511);

        // walled border, open middle
        drain_and_write(64'hff81_8181_8181_81ff, 4'd8, 4'd8, 8'd255);
        send_pose(15'd16384, 15'd16384, 9'd0);
        send_pose(15'd16384, 15'd16384, 9'd90);
        send_pose(15'd16384, 15'd16384, 9'd180);
        send_pose(15'd16384, 15'd16384, 9'd270);
        send_pose(15'd4096, 15'd4096, 9'd45);
        send_pose(15'd4096, 15'd28672, 9'd135);
        send_pose(15'd28672, 15'd28672, 9'd225);
        send_pose(15'd28672, 15'd4096, 9'd315);
        // standing on a wall and on a cell line
        send_pose(15'd0, 15'd0, 9'd300);
        send_pose(15'd4095, 15'd8192, 9'd30);
        send_pose(15'h7fff, 15'h7fff, 9'd400);
        send_pose(15'd12000, 15'd20000, 9'd271);

        // odd sizes and scale extremes
        drain_and_write(64'hffff_ffff_ffff_fffe, 4'd0, 4'd8, 8'd0);
        send_pose(15'd16384, 15'd16384, 9'd10);
        drain_and_write(64'haaaa_5555_aaaa_5555, 4'd15, 4'd15, 8'd1);
        send_pose(15'd20000, 15'd9000, 9'd200);
        send_pose(15'd1000, 15'd31000, 9'd359);
        drain_and_write(64'h0000_0000_0000_0002, 4'd1, 4'd3, 8'd128);
        send_pose(15'd100, 15'd100, 9'd0);
        send_pose(15'd100, 15'd5000, 9'd100);

        for (int ph = 0; ph < 10; ph++)
        begin
            cells = {$urandom, $urandom};
            if (ph % 3 == 0)
                cells = cells | {$urandom, $urandom};
            case (ph)
                0: drain_and_write(cells, 4'd8, 4'd8, 8'd255);
                1: drain_and_write(cells, 4'd1, 4'd1, 8'd1);
                2: drain_and_write(cells, 4'd15, 4'd0, 8'd0);
                default: drain_and_write(cells, 4'($urandom_range(15)),
                                         4'($urandom_range(15)), 8'($urandom));
            endcase
            if (ph < 3)
            begin
                send_idle_pct = 7;  pop_idle_pct = 46;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 46; pop_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;  pop_idle_pct = 0;
            end
            // back the block up: pop held off while poses keep coming
            if (ph == 6)
                hold_cycles = 4000;
            for (int i = 0; i < 25; i++)
                send_pose(15'($urandom), 15'($urandom), 9'($urandom));
        end
        push <= 1'b0;

        @(posedge clk);
        while (columns_pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
